/* sv/pfba_pkg.sv */
package pfba_pkg;

    // Map geometry.
    localparam int NUM_PAGES   = 2048;
    localparam int PAGE_SHIFT  = 12;
    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = NUM_PAGES / WORD_W;
    localparam int WORD_AW     = $clog2(NUM_WORDS);
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int IDX_W       = $clog2(NUM_PAGES);
    localparam int CNT_W       = IDX_W + 1;

    // The allocation scan looks at one slice of a word per cycle.
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_SEL_W = $clog2(WORD_W / CHUNK_W);
    localparam int CHUNK_BIT_W = $clog2(CHUNK_W);

    // Field widths.
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 12;
    localparam int TYPE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int PIDX_W      = ADDR_W - PAGE_SHIFT;
    localparam int S_TDATA_W   = ((ADDR_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ADDR_W;

    // Configuration registers.
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd2;

    localparam logic [ADDR_W-1:0] MEMORY_BASE_RST  = 32'h0020_0000;
    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h0020_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'h00A0_0000;

    // Request kinds.
    localparam logic [TYPE_W-1:0] REQ_INIT  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

    // Access to the bitmap memory.
    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } bm_req_t;

endpackage

/* sv/pfba_bitmap_ram.sv */
module pfba_bitmap_ram
    import pfba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  bm_req_t           ram_req,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] vld_reg;
    logic [WORD_W-1:0]    rd_q_reg;
    logic                 rd_vld_reg;

    // Storage array: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
        if (ram_req.rd_en) begin
            rd_q_reg <= mem[ram_req.rd_addr];
        end
    end

    // A word never written since reset reads as all pages used.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (ram_req.wr_en) begin
                vld_reg[ram_req.wr_addr] <= 1'b1;
            end
            if (ram_req.rd_en) begin
                rd_vld_reg <= vld_reg[ram_req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '1;

endmodule

/* sv/page_frame_bitmap_allocator_top.sv */
// Operation: init writes every bitmap word once; free reads and then writes each touched
// word; alloc scans the bitmap 8 pages per cycle, then reads and writes each word of
// the found run.
// Requests are taken one at a time; the read-modify-write of the bitmap memory never
// reads and writes in one cycle.
// Reset: aresetn is synchronous, active low; every page reads as used after reset.
module page_frame_bitmap_allocator_top
    import pfba_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // page_address[31:0], page_count[43:32]
    input  logic [TYPE_W-1:0]    s_tuser,   // req_type[1:0]
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // run_address[31:0]
    output logic [STATUS_W-1:0]  m_tuser,   // status[1:0]
    // Configuration writes.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PREP    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_SW_RD   = 3'd3;
    localparam logic [2:0] ST_SW_WR   = 3'd4;
    localparam logic [2:0] ST_INIT_WR = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    localparam logic [WORD_AW-1:0]     LAST_WORD  = WORD_AW'(NUM_WORDS - 1);
    localparam logic [CHUNK_SEL_W-1:0] LAST_CHUNK = CHUNK_SEL_W'(WORD_W / CHUNK_W - 1);
    localparam logic [CNT_W-1:0]       PAGES_CNT  = CNT_W'(NUM_PAGES);

    logic [2:0]             state_reg, state_next;
    logic [ADDR_W-1:0]      memory_base_reg, region_start_reg, region_end_reg;
    logic [TYPE_W-1:0]      req_type_reg, req_type_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [PIDX_W-1:0]      a_idx_reg, a_idx_next;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    logic [WORD_AW-1:0]     word_reg, word_next;
    logic [CHUNK_SEL_W-1:0] chunk_reg, chunk_next;
    logic [CNT_W-1:0]       run_reg, run_next;
    logic                   clear_mode_reg, clear_mode_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    bm_req_t                ram_req;
    logic [WORD_W-1:0]      rd_data;

    logic [PIDX_W-1:0]      req_idx;
    logic [PIDX_W-1:0]      rs_idx, re_idx;
    logic [CNT_W-1:0]       rs_clip, re_clip;
    logic [PIDX_W:0]        free_end;
    logic [CNT_W-1:0]       hi_m1;
    logic [WORD_AW-1:0]     sweep_last;
    logic [WORD_W-1:0]      word_mask;
    logic [CHUNK_W-1:0]     chunk_bits;
    logic [CNT_W-1:0]       scan_run;
    logic                   scan_hit;
    logic [CHUNK_BIT_W-1:0] scan_hit_bit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   out_free;

    // Pages of one word that fall inside [lo, hi).
    function automatic logic [WORD_W-1:0] range_mask(
        input logic [WORD_AW-1:0] w,
        input logic [CNT_W-1:0]   lo,
        input logic [CNT_W-1:0]   hi
    );
        logic [WORD_W-1:0] m;
        logic [CNT_W-1:0]  idx;
        for (int j = 0; j < WORD_W; j++) begin
            idx  = CNT_W'({w, BIT_W'(j)});
            m[j] = (idx >= lo) && (idx < hi);
        end
        return m;
    endfunction

    // Page index of an address, relative to the memory base.
    function automatic logic [PIDX_W-1:0] page_index(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] base
    );
        logic [ADDR_W-1:0] off;
        off = addr - base;
        return off[ADDR_W-1:PAGE_SHIFT];
    endfunction

    function automatic logic [CNT_W-1:0] clip_index(input logic [PIDX_W-1:0] idx);
        return (idx > PIDX_W'(NUM_PAGES)) ? PAGES_CNT : idx[CNT_W-1:0];
    endfunction

    pfba_bitmap_ram u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    // Index arithmetic for requests and the init region.
    assign req_idx    = page_index(s_tdata[ADDR_W-1:0], memory_base_reg);
    assign rs_idx     = page_index(region_start_reg, memory_base_reg);
    assign re_idx     = page_index(region_end_reg, memory_base_reg);
    assign rs_clip    = clip_index(rs_idx);
    assign re_clip    = clip_index(re_idx);
    assign free_end   = {1'b0, a_idx_reg} + (PIDX_W + 1)'(count_reg);
    assign hi_m1      = hi_reg - 1'b1;
    assign sweep_last = hi_m1[IDX_W-1:BIT_W];
    assign word_mask  = range_mask(word_reg, lo_reg, hi_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Scan step: follow the free-run length over one slice of the current word.
    assign chunk_bits = rd_data[chunk_reg*CHUNK_W +: CHUNK_W];
    always_comb begin
        scan_run     = run_reg;
        scan_hit     = 1'b0;
        scan_hit_bit = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (!scan_hit) begin
                if (chunk_bits[j]) begin
                    scan_run = '0;
                end else begin
                    scan_run = scan_run + 1'b1;
                end
                if (scan_run == count_reg) begin
                    scan_hit     = 1'b1;
                    scan_hit_bit = CHUNK_BIT_W'(j);
                end
            end
        end
    end
    assign hit_idx = {word_reg, chunk_reg, scan_hit_bit};

    // Request sequencer. Writes of one word always finish before the next word
    // or the next request reads, so accesses to one entry never overlap.
    always_comb begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        count_next      = count_reg;
        a_idx_next      = a_idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        word_next       = word_reg;
        chunk_next      = chunk_reg;
        run_next        = run_reg;
        clear_mode_next = clear_mode_reg;
        status_next     = status_reg;
        ram_req         = '0;
        ram_req.rd_addr = word_reg;
        ram_req.wr_addr = word_reg;
        ram_req.wr_data = clear_mode_reg ? (rd_data & ~word_mask) : (rd_data | word_mask);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_type_next = s_tuser;
                    count_next    = s_tdata[ADDR_W +: COUNT_W];
                    a_idx_next    = req_idx;
                    status_next   = STATUS_OK;
                    state_next    = ST_PREP;
                end
            end
            ST_PREP: begin
                word_next = '0;
                case (req_type_reg)
                    REQ_INIT: begin
                        lo_next    = rs_clip;
                        hi_next    = re_clip;
                        state_next = ST_INIT_WR;
                    end
                    REQ_ALLOC: begin
                        if (count_reg == '0 || count_reg > COUNT_W'(NUM_PAGES)) begin
                            status_next = STATUS_NO_SPACE;
                            state_next  = ST_DONE;
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = '0;
                            chunk_next      = '0;
                            run_next        = '0;
                            state_next      = ST_SCAN;
                        end
                    end
                    REQ_FREE: begin
                        clear_mode_next = 1'b1;
                        if (a_idx_reg < PIDX_W'(NUM_PAGES)) begin
                            lo_next = a_idx_reg[CNT_W-1:0];
                            if (free_end > (PIDX_W + 1)'(NUM_PAGES)) begin
                                hi_next     = PAGES_CNT;
                                status_next = STATUS_OUT_OF_RANGE;
                            end else begin
                                hi_next = free_end[CNT_W-1:0];
                            end
                        end else begin
                            // Out-of-map start; only a wrap past the top of the
                            // index space reaches pages in the map again.
                            lo_next = '0;
                            if (count_reg != '0) begin
                                status_next = STATUS_OUT_OF_RANGE;
                            end
                            if (free_end[PIDX_W]) begin
                                hi_next = clip_index(free_end[PIDX_W-1:0]);
                            end else begin
                                hi_next = '0;
                            end
                        end
                        state_next = ST_SW_RD;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    // The sweep restarts from the first word of the found run.
                    lo_next         = CNT_W'(hit_idx) + 1'b1 - count_reg;
                    hi_next         = CNT_W'(hit_idx) + 1'b1;
                    word_next       = '0;
                    clear_mode_next = 1'b0;
                    state_next      = ST_SW_RD;
                end else begin
                    run_next = scan_run;
                    if (chunk_reg == LAST_CHUNK) begin
                        if (word_reg == LAST_WORD) begin
                            status_next = STATUS_NO_SPACE;
                            state_next  = ST_DONE;
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = word_reg + 1'b1;
                            word_next       = word_reg + 1'b1;
                            chunk_next      = '0;
                        end
                    end else begin
                        chunk_next = chunk_reg + 1'b1;
                    end
                end
            end
            ST_SW_RD: begin
                if (lo_reg >= hi_reg) begin
                    state_next = ST_DONE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = lo_reg[IDX_W-1:BIT_W] > word_reg ?
                                      lo_reg[IDX_W-1:BIT_W] : word_reg;
                    word_next       = ram_req.rd_addr;
                    state_next      = ST_SW_WR;
                end
            end
            ST_SW_WR: begin
                ram_req.wr_en = 1'b1;
                if (word_reg == sweep_last) begin
                    state_next = ST_DONE;
                end else begin
                    word_next  = word_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_INIT_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_data = ~word_mask;
                if (word_reg == LAST_WORD) begin
                    state_next = ST_DONE;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register: takes a new result once the previous one has left.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = status_reg;
            if (req_type_reg == REQ_ALLOC && status_reg == STATUS_OK) begin
                m_tdata_next = memory_base_reg + (ADDR_W'(lo_reg) << PAGE_SHIFT);
            end else begin
                m_tdata_next = '0;
            end
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            memory_base_reg  <= MEMORY_BASE_RST;
            region_start_reg <= REGION_START_RST;
            region_end_reg   <= REGION_END_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MEMORY_BASE:  memory_base_reg  <= cfg_wdata;
                    CFG_REGION_START: region_start_reg <= cfg_wdata;
                    CFG_REGION_END:   region_end_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        req_type_reg   <= req_type_next;
        count_reg      <= count_next;
        a_idx_reg      <= a_idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        word_reg       <= word_next;
        chunk_reg      <= chunk_next;
        run_reg        <= run_next;
        clear_mode_reg <= clear_mode_next;
        status_reg     <= status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The bitmap is written only by the sweep and init states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> (state_reg == ST_SW_WR || state_reg == ST_INIT_WR))
        else $error("bitmap write outside a write state");

    // A read and a write of the bitmap never share a cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.wr_en && ram_req.rd_en))
        else $error("bitmap read and write in the same cycle");

    // The free run carried into a scan step is shorter than the requested count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (run_reg < count_reg))
        else $error("scan run length reached the count without a hit");

    // A sweep write stays within the words of the page range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SW_WR) |->
            (word_reg >= lo_reg[IDX_W-1:BIT_W] && word_reg <= sweep_last))
        else $error("sweep write outside the page range");

    // A result is only loaded from the done state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

endmodule
